FILE: design/bfse_pkg.sv
// ----------------------------------------------------------------------------
// bfse_pkg
// Shared constants, opcodes, status codes and the source decoder for the
// step engine.
// ----------------------------------------------------------------------------
package bfse_pkg;

    // Default sizes
    localparam int unsigned DEF_PROG_DEPTH = 1024;
    localparam int unsigned DEF_TAPE_DEPTH = 1024;
    localparam int unsigned DEF_NEST_DEPTH = 64;

    // Fixed field widths
    localparam int unsigned BRK_W    = 11;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned IN_DW    = 24;
    localparam int unsigned OUT_DW   = 24;

    // Stored opcodes
    typedef enum logic [2:0] {
        OP_LEFT  = 3'd0,
        OP_RIGHT = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_DONE    = 3'd0,
        STAT_END     = 3'd1,
        STAT_BREAK   = 3'd2,
        STAT_UNBAL   = 3'd3,
        STAT_TAPE    = 3'd4,
        STAT_IGNORED = 3'd5,
        STAT_FULL    = 3'd6
    } status_t;

    // Request modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    typedef struct packed {
        logic is_cmd;
        op_t  op;
    } decoded_t;

    // Source character to opcode
    function automatic decoded_t decode_symbol(input logic [7:0] c);
        decoded_t d;
        d.is_cmd = 1'b1;
        d.op     = OP_LEFT;
        case (c)
            8'h3C: d.op = OP_LEFT;
            8'h3E: d.op = OP_RIGHT;
            8'h2B: d.op = OP_INC;
            8'h2D: d.op = OP_DEC;
            8'h2E: d.op = OP_OUT;
            8'h2C: d.op = OP_IN;
            8'h5B: d.op = OP_OPEN;
            8'h5D: d.op = OP_CLOSE;
            default: d.is_cmd = 1'b0;
        endcase
        return d;
    endfunction

endpackage

FILE: design/brainfuck_step_engine.sv
// ----------------------------------------------------------------------------
// brainfuck_step_engine
// Step engine: loads source into program and jump memories, executes one
// instruction per request against a byte tape.
// ----------------------------------------------------------------------------
// channel   dir  payload (low bit first)
// s_axis    in   mode[1:0] symbol[9:2] input_byte[17:10]
// m_axis    out  status[2:0] out_valid[3] out_byte[11:4] position[22:12]
// cfg       in   index 0 break_first, index 1 break_second
//
// A request is taken in the idle cycle, memories are read there, and the
// work cycle after computes and writes back. A load of ']' adds the
// S_JFIX state for the second jump memory write. A clear request adds a
// sweep that zeroes all TAPE_DEPTH tape cells; the same sweep runs after
// reset before the first request. A full output register stalls the work
// cycle; the next request is taken while a result waits.
// ----------------------------------------------------------------------------
module brainfuck_step_engine
    import bfse_pkg::*;
#(
    parameter int unsigned PROG_DEPTH = DEF_PROG_DEPTH,
    parameter int unsigned TAPE_DEPTH = DEF_TAPE_DEPTH,
    parameter int unsigned NEST_DEPTH = DEF_NEST_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // mode, symbol, input_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // status, out_valid, out_byte, position
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [BRK_W-1:0]  cfg_data
);

    localparam int unsigned PAW = $clog2(PROG_DEPTH);
    localparam int unsigned CW  = $clog2(PROG_DEPTH + 1);
    localparam int unsigned TAW = $clog2(TAPE_DEPTH);
    localparam int unsigned SAW = $clog2(NEST_DEPTH);
    localparam int unsigned DW  = $clog2(NEST_DEPTH + 1);
    localparam int unsigned BW  = (CW > BRK_W) ? CW : BRK_W;
    localparam int unsigned XW  = (BW > POS_W) ? BW : POS_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WORK,
        S_JFIX
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [7:0]          sym_reg, sym_next;
    logic [7:0]          ib_reg, ib_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       ctr_reg, ctr_next;
    logic [TAW-1:0]      cp_reg, cp_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [1:0]          armed_reg, armed_next;
    logic                berr_reg, berr_next;
    logic [BRK_W-1:0]    bk1_reg, bk2_reg;
    logic [TAW-1:0]      clr_addr_reg, clr_addr_next;
    logic                clr_emit_reg, clr_emit_next;
    logic [PAW-1:0]      jfix_addr_reg, jfix_addr_next;
    logic [PAW-1:0]      jfix_val_reg, jfix_val_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DW-1:0]   m_tdata_reg, m_tdata_next;

    // Memory ports
    logic                prog_we;
    logic [PAW-1:0]      prog_waddr;
    op_t                 prog_wdata;
    logic [2:0]          prog_rdata;
    logic                jump_we;
    logic [PAW-1:0]      jump_waddr, jump_wdata, jump_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [PAW-1:0]      stk_wdata, stk_rdata;
    logic                tape_we;
    logic [TAW-1:0]      tape_waddr;
    logic [7:0]          tape_wdata, tape_rdata;
    logic [DW-1:0]       depth_dec;

    bfse_ram #(.WIDTH(3), .DEPTH(PROG_DEPTH)) u_prog (
        .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
        .raddr(ctr_reg[PAW-1:0]), .rdata(prog_rdata)
    );

    bfse_ram #(.WIDTH(PAW), .DEPTH(PROG_DEPTH)) u_jump (
        .clk(clk), .we(jump_we), .waddr(jump_waddr), .wdata(jump_wdata),
        .raddr(ctr_reg[PAW-1:0]), .rdata(jump_rdata)
    );

    assign depth_dec = depth_reg - DW'(1);
    assign stk_raddr = depth_dec[SAW-1:0];

    bfse_ram #(.WIDTH(PAW), .DEPTH(NEST_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    bfse_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
        .raddr(cp_reg), .rdata(tape_rdata)
    );

    // Handshake and ports
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Work cycle helpers
    decoded_t       dec;
    logic [BW-1:0]  pc_ext, bk1_ext, bk2_ext;
    logic           hit1, hit2;
    logic [CW-1:0]  ctr_inc, jump_ext;
    logic [XW-1:0]  pos_ext;
    status_t        res_status;
    logic           res_valid;
    logic [7:0]     res_byte;
    logic           res_fire;

    assign dec     = decode_symbol(sym_reg);
    assign pc_ext  = BW'(ctr_reg);
    assign bk1_ext = BW'(bk1_reg);
    assign bk2_ext = BW'(bk2_reg);
    assign hit1    = armed_reg[0] && !bk1_reg[BRK_W-1] && (bk1_ext == pc_ext);
    assign hit2    = armed_reg[1] && !bk2_reg[BRK_W-1] && (bk2_ext == pc_ext);
    assign ctr_inc = ctr_reg + CW'(1);
    assign jump_ext = CW'(jump_rdata);
    assign pos_ext = XW'(ctr_next);

    // Next state, write-back and result
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        sym_next       = sym_reg;
        ib_next        = ib_reg;
        len_next       = len_reg;
        ctr_next       = ctr_reg;
        cp_next        = cp_reg;
        depth_next     = depth_reg;
        armed_next     = armed_reg;
        berr_next      = berr_reg;
        clr_addr_next  = clr_addr_reg;
        clr_emit_next  = clr_emit_reg;
        jfix_addr_next = jfix_addr_reg;
        jfix_val_next  = jfix_val_reg;
        prog_we        = 1'b0;
        prog_waddr     = len_reg[PAW-1:0];
        prog_wdata     = dec.op;
        jump_we        = 1'b0;
        jump_waddr     = len_reg[PAW-1:0];
        jump_wdata     = '0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[SAW-1:0];
        stk_wdata      = len_reg[PAW-1:0];
        tape_we        = 1'b0;
        tape_waddr     = cp_reg;
        tape_wdata     = 8'd0;
        res_status     = STAT_DONE;
        res_valid      = 1'b0;
        res_byte       = 8'd0;
        res_fire       = 1'b0;

        case (state_reg)
            // Tape sweep after reset or a clear request
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_addr_reg;
                if (clr_addr_reg == TAW'(TAPE_DEPTH - 1))
                begin
                    if (!clr_emit_reg || out_free)
                    begin
                        res_fire      = clr_emit_reg;
                        clr_emit_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + TAW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tdata[1:0];
                    sym_next   = s_tdata[9:2];
                    ib_next    = s_tdata[17:10];
                    state_next = S_WORK;
                end
            end

            S_WORK:
            begin
                if (out_free)
                begin
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                    case (mode_reg)
                        MODE_CLEAR:
                        begin
                            res_fire      = 1'b0;
                            len_next      = '0;
                            ctr_next      = '0;
                            cp_next       = '0;
                            depth_next    = '0;
                            armed_next    = 2'b11;
                            berr_next     = 1'b0;
                            clr_addr_next = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end

                        MODE_LOAD:
                        begin
                            if (!dec.is_cmd)
                            begin
                                res_status = STAT_IGNORED;
                            end
                            else if (len_reg == CW'(PROG_DEPTH))
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                prog_we  = 1'b1;
                                len_next = len_reg + CW'(1);
                                if (dec.op == OP_OPEN)
                                begin
                                    if (depth_reg == DW'(NEST_DEPTH))
                                    begin
                                        berr_next  = 1'b1;
                                        res_status = STAT_UNBAL;
                                    end
                                    else
                                    begin
                                        stk_we     = 1'b1;
                                        depth_next = depth_reg + DW'(1);
                                    end
                                end
                                else if (dec.op == OP_CLOSE)
                                begin
                                    if (depth_reg == '0)
                                    begin
                                        berr_next  = 1'b1;
                                        res_status = STAT_UNBAL;
                                    end
                                    else
                                    begin
                                        // partner pairing: this entry now,
                                        // the open entry next cycle
                                        depth_next     = depth_dec;
                                        jump_we        = 1'b1;
                                        jump_wdata     = stk_rdata;
                                        jfix_addr_next = stk_rdata;
                                        jfix_val_next  = len_reg[PAW-1:0];
                                        state_next     = S_JFIX;
                                    end
                                end
                            end
                        end

                        MODE_EXEC:
                        begin
                            if (berr_reg || depth_reg != '0)
                            begin
                                res_status = STAT_UNBAL;
                            end
                            else if (ctr_reg >= len_reg)
                            begin
                                res_status = STAT_END;
                            end
                            else if (hit1)
                            begin
                                armed_next[0] = 1'b0;
                                res_status    = STAT_BREAK;
                            end
                            else if (hit2)
                            begin
                                armed_next[1] = 1'b0;
                                res_status    = STAT_BREAK;
                            end
                            else
                            begin
                                ctr_next = ctr_inc;
                                case (op_t'(prog_rdata))
                                    OP_LEFT:
                                    begin
                                        if (cp_reg != '0)
                                        begin
                                            cp_next = cp_reg - TAW'(1);
                                        end
                                    end
                                    OP_RIGHT:
                                    begin
                                        if (cp_reg == TAW'(TAPE_DEPTH - 1))
                                        begin
                                            res_status = STAT_TAPE;
                                        end
                                        else
                                        begin
                                            cp_next = cp_reg + TAW'(1);
                                        end
                                    end
                                    OP_INC:
                                    begin
                                        tape_we    = 1'b1;
                                        tape_wdata = tape_rdata + 8'd1;
                                    end
                                    OP_DEC:
                                    begin
                                        tape_we    = 1'b1;
                                        tape_wdata = tape_rdata - 8'd1;
                                    end
                                    OP_OUT:
                                    begin
                                        res_valid = 1'b1;
                                        res_byte  = tape_rdata;
                                    end
                                    OP_IN:
                                    begin
                                        tape_we    = 1'b1;
                                        tape_wdata = ib_reg;
                                    end
                                    OP_OPEN:
                                    begin
                                        if (tape_rdata == 8'd0)
                                        begin
                                            ctr_next = jump_ext + CW'(1);
                                        end
                                    end
                                    default:
                                    begin
                                        ctr_next = jump_ext;
                                    end
                                endcase
                            end
                        end

                        default:
                        begin
                            res_status = STAT_IGNORED;
                        end
                    endcase
                end
            end

            // Second jump memory write of a bracket pair
            S_JFIX:
            begin
                jump_we    = 1'b1;
                jump_waddr = jfix_addr_reg;
                jump_wdata = jfix_val_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, pos_ext[POS_W-1:0], res_byte, res_valid, res_status};
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= MODE_CLEAR;
            sym_reg       <= 8'd0;
            ib_reg        <= 8'd0;
            len_reg       <= '0;
            ctr_reg       <= '0;
            cp_reg        <= '0;
            depth_reg     <= '0;
            armed_reg     <= 2'b11;
            berr_reg      <= 1'b0;
            bk1_reg       <= '1;
            bk2_reg       <= '1;
            clr_addr_reg  <= '0;
            clr_emit_reg  <= 1'b0;
            jfix_addr_reg <= '0;
            jfix_val_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            sym_reg       <= sym_next;
            ib_reg        <= ib_next;
            len_reg       <= len_next;
            ctr_reg       <= ctr_next;
            cp_reg        <= cp_next;
            depth_reg     <= depth_next;
            armed_reg     <= armed_next;
            berr_reg      <= berr_next;
            clr_addr_reg  <= clr_addr_next;
            clr_emit_reg  <= clr_emit_next;
            jfix_addr_reg <= jfix_addr_next;
            jfix_val_reg  <= jfix_val_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            if (cfg_wr_en && !cfg_index)
            begin
                bk1_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index)
            begin
                bk2_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: design/bfse_ram.sv
// ----------------------------------------------------------------------------
// bfse_ram
// Single write, single read synchronous memory, registered read data.
// ----------------------------------------------------------------------------
module bfse_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bfse_checker.sv
// ----------------------------------------------------------------------------
// bfse_checker
// Port-level checks on the step engine's result stream.
// ----------------------------------------------------------------------------
module bfse_checker
    import bfse_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no byte without the output flag
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0)
        else $error("byte set without output flag");

    // an output only comes from an executed instruction
    a_outst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == STAT_DONE)
        else $error("output with non-done status");

    // status code in range, pad bit clear
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] != 3'd7 && !m_tdata[OUT_DW-1])
        else $error("bad status code");

endmodule

bind brainfuck_step_engine bfse_checker u_bfse_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for brainfuck_step_engine. A predictor in the bench
// keeps its own program, jump table, tape and breakpoint state. Every accepted
// request pushes the expected result onto a queue. A checker pops one entry
// for each result the block hands over and compares the fields one by one.
// ----------------------------------------------------------------------------
module testbench;
    import bfse_pkg::*;

    localparam int PROG_MAX   = 1024;
    localparam int TAPE_CELLS = 1024;
    localparam int NEST_MAX   = 64;
    localparam int LIMIT      = 1000000;

    typedef struct packed {
        status_t     status;
        logic        out_valid;
        logic [7:0]  out_val;
        logic [10:0] position;
    } step_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [BRK_W-1:0]  cfg_data;

    // predictor state
    op_t         code_ops [PROG_MAX];
    int          jump_to [PROG_MAX];
    int          open_at [NEST_MAX];
    int          nest, code_len, pc_now, cell_at;
    logic [7:0]  tape [TAPE_CELLS];
    logic [1:0]  armed;
    logic        brackets_bad;
    logic [10:0] brk [2];

    step_result_t expected_results[$];
    int          errors;
    int          cycles;
    bit          idling;
    int          hold_cycles;

    brainfuck_step_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= idling ? ($urandom_range(99) >= 38) : 1'b1;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        step_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report("unexpected result, data", int'(m_tdata), 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report("status", int'(m_tdata[2:0]), int'(want.status));
                if (m_tdata[3] !== want.out_valid)
                    report("out_valid", int'(m_tdata[3]), int'(want.out_valid));
                if (m_tdata[11:4] !== want.out_val)
                    report("out_byte", int'(m_tdata[11:4]), int'(want.out_val));
                if (m_tdata[22:12] !== want.position)
                    report("position", int'(m_tdata[22:12]), int'(want.position));
                if (m_tdata[23] !== 1'b0)
                    report("pad bit", int'(m_tdata[23]), 0);
            end
        end
    end

    function automatic void wipe_machine();
        for (int i = 0; i < TAPE_CELLS; i++)
            tape[i] = 8'd0;
        nest         = 0;
        code_len     = 0;
        pc_now       = 0;
        cell_at      = 0;
        armed        = 2'b11;
        brackets_bad = 1'b0;
    endfunction

    function automatic bit break_hit(input logic [10:0] r, input int pos);
        return !r[10] && (int'(r) == pos);
    endfunction

    function automatic status_t load_char(input logic [7:0] c);
        op_t op;
        int  at;
        case (c)
            "<": op = OP_LEFT;
            ">": op = OP_RIGHT;
            "+": op = OP_INC;
            "-": op = OP_DEC;
            ".": op = OP_OUT;
            ",": op = OP_IN;
            "[": op = OP_OPEN;
            "]": op = OP_CLOSE;
            default: return STAT_IGNORED;
        endcase
        if (code_len >= PROG_MAX)
            return STAT_FULL;
        at = code_len;
        code_ops[at] = op;
        jump_to[at]  = 0;
        code_len++;
        if (op == OP_OPEN)
        begin
            if (nest >= NEST_MAX)
            begin
                brackets_bad = 1'b1;
                return STAT_UNBAL;
            end
            open_at[nest] = at;
            nest++;
        end
        else if (op == OP_CLOSE)
        begin
            if (nest == 0)
            begin
                brackets_bad = 1'b1;
                return STAT_UNBAL;
            end
            nest--;
            jump_to[open_at[nest]] = at;
            jump_to[at] = open_at[nest];
        end
        return STAT_DONE;
    endfunction

    // works out the result of one request and advances the predictor
    function automatic step_result_t predict_step(input logic [1:0] mode,
                                                  input logic [7:0] sym,
                                                  input logic [7:0] in_byte);
        step_result_t r;
        int pc;
        r = '0;
        r.status = STAT_DONE;
        if (mode == MODE_CLEAR)
            wipe_machine();
        else if (mode == MODE_LOAD)
            r.status = load_char(sym);
        else if (mode != MODE_EXEC)
            r.status = STAT_IGNORED;
        else if (brackets_bad || nest != 0)
            r.status = STAT_UNBAL;
        else if (pc_now >= code_len)
            r.status = STAT_END;
        else if (armed[0] && break_hit(brk[0], pc_now))
        begin
            armed[0] = 1'b0;
            r.status = STAT_BREAK;
        end
        else if (armed[1] && break_hit(brk[1], pc_now))
        begin
            armed[1] = 1'b0;
            r.status = STAT_BREAK;
        end
        else
        begin
            pc = pc_now;
            case (code_ops[pc])
                OP_LEFT:  if (cell_at > 0) cell_at--;
                OP_RIGHT:
                    if (cell_at + 1 < TAPE_CELLS)
                        cell_at++;
                    else
                        r.status = STAT_TAPE;
                OP_INC:   tape[cell_at] = tape[cell_at] + 8'd1;
                OP_DEC:   tape[cell_at] = tape[cell_at] - 8'd1;
                OP_OUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_val   = tape[cell_at];
                end
                OP_IN:    tape[cell_at] = in_byte;
                OP_OPEN:  if (tape[cell_at] == 8'd0) pc = jump_to[pc];
                default:  pc = jump_to[pc] - 1;
            endcase
            pc_now = pc + 1;
        end
        r.position = pc_now[10:0];
        return r;
    endfunction

    // sends one request, gaps at random first
    task automatic send_item(input logic [1:0] mode, input logic [7:0] sym,
                             input logic [7:0] in_byte);
        while (idling && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, in_byte, sym, mode};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_step(mode, sym, in_byte));
    endtask

    task automatic load_text(input string src);
        for (int i = 0; i < src.len(); i++)
            send_item(MODE_LOAD, src[i], 8'($urandom));
    endtask

    task automatic run_steps(input int n);
        for (int i = 0; i < n; i++)
            send_item(MODE_EXEC, 8'($urandom), 8'($urandom));
    endtask

    // lets all results drain so the registers may be written
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_breaks(input logic [10:0] first, input logic [10:0] second);
        cfg_wr_en <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= 1'b1;
        cfg_data  <= second;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        brk[0] = first;
        brk[1] = second;
    endtask

    task automatic test_each_command();
        send_item(MODE_CLEAR, 8'h00, 8'hFF);
        send_item(2'd3, 8'hFF, 8'h00);
        send_item(MODE_LOAD, 8'h41, 8'h00);
        load_text("<,+.-.>[-].");
        run_steps(14);
        drain();
    endtask

    task automatic test_unbalanced();
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("]+");
        run_steps(2);
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("[+");
        run_steps(1);
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        for (int i = 0; i <= NEST_MAX; i++)
            send_item(MODE_LOAD, "[", 8'h00);
        run_steps(1);
        drain();
    endtask

    task automatic test_breakpoints();
        set_breaks(11'd2, 11'd2);
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("+++.");
        run_steps(7);
        // writing again does not re-arm; a clear does
        drain();
        set_breaks(11'd0, 11'd1023);
        run_steps(1);
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("+.");
        run_steps(4);
        drain();
        set_breaks(11'h400, 11'h7FF);
    endtask

    task automatic test_program_full();
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        for (int i = 0; i < PROG_MAX + 1; i++)
            send_item(MODE_LOAD, "+", 8'h00);
        send_item(MODE_LOAD, "x", 8'h00);
        run_steps(3);
        drain();
    endtask

    task automatic test_tape_limit();
        idling = 1'b0;
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("+[>+]");
        run_steps(4 * TAPE_CELLS + 40);
        drain();
        idling = 1'b1;
    endtask

    task automatic test_backpressure();
        send_item(MODE_CLEAR, 8'h00, 8'h00);
        load_text("++[.-]");
        hold_cycles = 300;
        run_steps(30);
        drain();
    endtask

    function automatic logic [10:0] pick_break(input int len);
        case ($urandom_range(4))
            0: return 11'h7FF;
            1: return 11'd1023;
            2: return 11'($urandom);
            default: return 11'($urandom_range(len));
        endcase
    endfunction

    task automatic test_random_programs();
        int    sent, len, open_n;
        string src;
        byte   ch;
        sent = 0;
        while (sent < 450)
        begin
            src = "";
            open_n = 0;
            len = $urandom_range(3, 16);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(9))
                    0: ch = "<";
                    1: ch = ">";
                    2, 3: ch = "+";
                    4: ch = "-";
                    5: ch = ".";
                    6: ch = ",";
                    7: ch = (open_n < 4) ? "[" : "+";
                    8: ch = (open_n > 0) ? "]" : "-";
                    default: ch = 8'($urandom);
                endcase
                if (ch == "[") open_n++;
                if (ch == "]") open_n--;
                src = {src, string'(ch)};
            end
            // mostly close the loops, sometimes leave them open
            if ($urandom_range(9) != 0)
                repeat (open_n) src = {src, "]"};
            drain();
            set_breaks(pick_break(src.len()), pick_break(src.len()));
            send_item(MODE_CLEAR, 8'($urandom), 8'($urandom));
            load_text(src);
            len = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(19) == 0)
                    send_item(2'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_item(MODE_EXEC, 8'($urandom), 8'($urandom));
            end
            sent += src.len() + len + 1;
        end
        drain();
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        idling      = 1'b1;
        hold_cycles = 0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        brk[0]      = 11'h7FF;
        brk[1]      = 11'h7FF;
        wipe_machine();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_breaks(11'h7FF, 11'h7FF);

        test_each_command();
        test_unbalanced();
        test_breakpoints();
        test_program_full();
        test_tape_limit();
        test_backpressure();
        test_random_programs();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
